// ----- src/bmlfq_pkg.sv -----
// Shared types, codes and defaults of the MLFQ priority engine.
package bmlfq_pkg;

  localparam int MAX_THREADS_DEF = 64;
  localparam int FRAC_BITS_DEF   = 14;

  localparam int IDX_W  = 6;
  localparam int RC_W   = 32;
  localparam int APB_AW = 4;

  localparam int PRIO_TOP = 63;
  localparam int NICE_LIM = 20;
  localparam int RX_LIM   = 2000000;
  localparam int LX_LIM   = 6400;
  localparam int SCALE    = 100;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_SLICE  = 2'd1;
  localparam logic [1:0] REG_TPS    = 2'd2;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_EXIT   = 3'd2,
    ACT_NICE   = 3'd3,
    ACT_SLICE  = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef struct packed {
    logic signed [5:0]      nice;
    logic signed [RC_W-1:0] rcpu;
    logic [5:0]             prio;
  } thread_rec_t;

endpackage

// ----- src/bsd_mlfq_priority_engine.sv -----
// MLFQ priority engine: per-thread nice/cpu usage/priority and load average.
//
//  channel  direction  handshake                     payload
//  in       to block   start & !busy accepts         in_action .. in_running_is_idle
//  out      from block out_valid, one cycle          out_priority_res .. out_yield_request
//  cfg      to block   APB, write at psel&penable    psel penable pwrite paddr pwdata
//
// One request at a time; busy rises at acceptance and drops in the result strobe cycle.
// A plain request passes S_WRAP, which subtracts MAX_THREADS until the indexes fit, then S_ACT and
// the result states S_ORD, S_OMA, S_OMB and S_OFN. An enabled tick on a quarter boundary adds a
// priority sweep over all slots that rewrites each live thread. An enabled tick on a second
// boundary adds the load update, restoring divider and a decay sweep through the shared multiplier.
// rst_n is synchronous; it spares the table and work registers. The result receiver cannot stall.
module bsd_mlfq_priority_engine
  import bmlfq_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_action,
  input  logic [5:0]          in_thread_index,
  input  logic [5:0]          in_parent_index,
  input  logic signed [5:0]   in_nice_value,
  input  logic [6:0]          in_ready_count,
  input  logic                in_running_is_idle,
  output logic                out_valid,
  output logic [5:0]          out_priority_res,
  output logic signed [21:0]  out_cpu_usage_x100,
  output logic [12:0]         out_load_avg_x100,
  output logic                out_yield_request,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int TW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int SW    = $clog2(MAX_THREADS + 1);
  localparam int MB_W  = FRAC_BITS + 2;
  localparam int PW    = RC_W + MB_W;
  localparam int DW    = RC_W + 3;
  localparam int DCW   = $clog2(FRAC_BITS + 1);
  localparam int FONE  = 1 << FRAC_BITS;
  localparam int HALF  = FONE / 2;
  localparam int C59   = (59 * FONE) / 60;
  localparam int C1    = FONE / 60;
  localparam logic [8:0]    M9    = 9'(MAX_THREADS);
  localparam logic [SW-1:0] M_END = SW'(MAX_THREADS);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_WRAP = 15'h0002,
    S_ACT  = 15'h0004,
    S_LOAD = 15'h0008,
    S_DVI  = 15'h0010,
    S_DIV  = 15'h0020,
    S_DRD  = 15'h0040,
    S_DWT  = 15'h0080,
    S_DWR  = 15'h0100,
    S_PRD  = 15'h0200,
    S_PWR  = 15'h0400,
    S_ORD  = 15'h0800,
    S_OMA  = 15'h1000,
    S_OMB  = 15'h2000,
    S_OFN  = 15'h4000
  } state_t;

  // Fixed-point helpers: truncate toward zero, round half away from zero, saturate.
  function automatic logic signed [PW-1:0] trunc_p(input logic signed [PW-1:0] x);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    mag = x[PW-1] ? PW'(-x) : PW'(x);
    q   = mag >> FRAC_BITS;
    return x[PW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [PW-1:0] round_p(input logic signed [PW-1:0] x);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    mag = x[PW-1] ? PW'(-x) : PW'(x);
    q   = (mag + PW'(HALF)) >> FRAC_BITS;
    return x[PW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [RC_W-1:0] sat32(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'(32'sh7FFF_FFFF);
    lo = PW'(32'sh8000_0000);
    if (x > hi) return 32'sh7FFF_FFFF;
    if (x < lo) return 32'sh8000_0000;
    return x[RC_W-1:0];
  endfunction

  function automatic logic [5:0] calc_prio(input logic signed [RC_W-1:0] rc,
                                           input logic signed [5:0] nv);
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] p;
    x = PW'(rc);
    q = x[PW-1] ? ((x + PW'(3)) >>> 2) : (x >>> 2);
    q = round_p(q);
    p = PW'(PRIO_TOP) - q - (PW'(nv) <<< 1);
    if (p > PW'(PRIO_TOP)) return 6'(PRIO_TOP);
    if (p < 0) return 6'd0;
    return p[5:0];
  endfunction

  // Control state
  state_t                  state_r, state_nxt;
  logic [MAX_THREADS-1:0]  live_r, live_nxt;
  logic signed [RC_W-1:0]  load_r, load_nxt;
  logic [9:0]              sec_r, sec_nxt;
  logic [1:0]              qtr_r, qtr_nxt;
  logic [7:0]              slc_r, slc_nxt;
  logic                    en_r, en_nxt;
  logic [7:0]              tsl_r, tsl_nxt;
  logic [9:0]              tps_r, tps_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Request and work registers
  logic [2:0]              act_r, act_nxt;
  logic [5:0]              idx_r, idx_nxt;
  logic [5:0]              par_r, par_nxt;
  logic signed [5:0]       nv_r, nv_nxt;
  logic [6:0]              rdy_r, rdy_nxt;
  logic                    idle_r, idle_nxt;
  logic                    yield_r, yield_nxt;
  logic                    pflag_r, pflag_nxt;
  logic [SW-1:0]           sweep_r, sweep_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [DW-2:0]           den_r, den_nxt;
  logic [FRAC_BITS-1:0]    coeff_r, coeff_nxt;
  logic [DCW-1:0]          dcnt_r, dcnt_nxt;
  logic signed [21:0]      rx_r, rx_nxt;
  logic [5:0]              oprio_r, oprio_nxt;
  logic signed [21:0]      orx_r, orx_nxt;
  logic [12:0]             olx_r, olx_nxt;
  logic                    oyld_r, oyld_nxt;

  // Shared multiplier
  logic signed [RC_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    mul_p_r;

  // Thread table
  thread_rec_t             thread_mem [MAX_THREADS];
  thread_rec_t             rdq_r;
  thread_rec_t             wr_data;
  logic                    rd_en, wr_en;
  logic [TW-1:0]           rd_addr, wr_addr;

  logic [TW-1:0]           idx_w, par_w, swp_w;
  logic                    cfg_wr;
  logic [9:0]              tps_eff, sec_inc;
  logic                    sec_hit, qtr_hit;
  logic [7:0]              slc_inc;
  logic signed [RC_W:0]    twice;
  logic [DW-1:0]           div_sh;
  logic signed [PW-1:0]    calc_v;
  logic signed [5:0]       nv_sat;
  logic [5:0]              new_prio;
  logic signed [RC_W-1:0]  new_rc;
  logic signed [5:0]       new_nice;

  assign idx_w   = TW'(idx_r);
  assign par_w   = TW'(par_r);
  assign swp_w   = sweep_r[TW-1:0];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign busy    = (state_r != S_IDLE);

  assign tps_eff = (tps_r == 10'd0) ? 10'd1 : tps_r;
  assign sec_inc = sec_r + 10'd1;
  assign sec_hit = (sec_inc >= tps_eff);
  assign qtr_hit = ((qtr_r + 2'd1) == 2'd0);
  assign slc_inc = (slc_r == 8'hFF) ? slc_r : slc_r + 8'd1;
  assign twice   = load_r[RC_W-1] ? '0 : $signed({load_r, 1'b0});
  assign div_sh  = {rem_r[DW-2:0], 1'b0};
  assign nv_sat  = (nv_r > 6'sd20) ? 6'sd20 : ((nv_r < -6'sd20) ? -6'sd20 : nv_r);

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, en_r};
      REG_SLICE:  prdata = {24'd0, tsl_r};
      REG_TPS:    prdata = {22'd0, tps_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    load_nxt      = load_r;
    sec_nxt       = sec_r;
    qtr_nxt       = qtr_r;
    slc_nxt       = slc_r;
    en_nxt        = en_r;
    tsl_nxt       = tsl_r;
    tps_nxt       = tps_r;
    out_valid_nxt = 1'b0;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    par_nxt       = par_r;
    nv_nxt        = nv_r;
    rdy_nxt       = rdy_r;
    idle_nxt      = idle_r;
    yield_nxt     = yield_r;
    pflag_nxt     = pflag_r;
    sweep_nxt     = sweep_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    coeff_nxt     = coeff_r;
    dcnt_nxt      = dcnt_r;
    rx_nxt        = rx_r;
    oprio_nxt     = oprio_r;
    orx_nxt       = orx_r;
    olx_nxt       = olx_r;
    oyld_nxt      = oyld_r;
    mul_a         = load_r;
    mul_b         = MB_W'(SCALE);
    rd_en         = 1'b0;
    rd_addr       = idx_w;
    wr_en         = 1'b0;
    wr_addr       = idx_w;
    wr_data       = rdq_r;
    calc_v        = '0;
    new_prio      = '0;
    new_rc        = '0;
    new_nice      = '0;

    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ENABLE: en_nxt  = pwdata[0];
        REG_SLICE:  tsl_nxt = pwdata[7:0];
        REG_TPS:    tps_nxt = pwdata[9:0];
        default:    ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          idx_nxt   = in_thread_index;
          par_nxt   = in_parent_index;
          nv_nxt    = in_nice_value;
          rdy_nxt   = in_ready_count;
          idle_nxt  = in_running_is_idle;
          yield_nxt = 1'b0;
          pflag_nxt = 1'b0;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        // Wrap indexes into the table, one subtract per cycle
        if ({3'd0, idx_r} >= M9) idx_nxt = idx_r - M9[5:0];
        if ({3'd0, par_r} >= M9) par_nxt = par_r - M9[5:0];
        if (({3'd0, idx_r} < M9) && ({3'd0, par_r} < M9)) begin
          rd_en     = 1'b1;
          rd_addr   = (act_r == ACT_CREATE) ? par_w : idx_w;
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        state_nxt = S_ORD;
        unique case (act_r)
          ACT_TICK: begin
            if (en_r && !idle_r && live_r[idx_w]) begin
              wr_en   = 1'b1;
              wr_data = '{nice: rdq_r.nice,
                          rcpu: sat32(PW'(rdq_r.rcpu) + PW'(FONE)),
                          prio: rdq_r.prio};
            end
            sec_nxt   = sec_hit ? 10'd0 : sec_inc;
            qtr_nxt   = qtr_r + 2'd1;
            slc_nxt   = slc_inc;
            yield_nxt = (slc_inc >= tsl_r);
            pflag_nxt = en_r && qtr_hit;
            if (en_r && sec_hit) begin
              mul_a     = load_r;
              mul_b     = MB_W'(C59);
              state_nxt = S_LOAD;
            end else if (en_r && qtr_hit) begin
              sweep_nxt = '0;
              state_nxt = S_PRD;
            end
          end
          ACT_CREATE: begin
            new_nice = (par_r == idx_r) ? 6'sd0 : rdq_r.nice;
            new_rc   = (par_r == idx_r) ? '0 : rdq_r.rcpu;
            new_prio = calc_prio(new_rc, new_nice);
            wr_en    = 1'b1;
            wr_data  = '{nice: new_nice, rcpu: new_rc, prio: new_prio};
            live_nxt[idx_w] = 1'b1;
          end
          ACT_EXIT: begin
            live_nxt[idx_w] = 1'b0;
          end
          ACT_NICE: begin
            new_prio  = calc_prio(rdq_r.rcpu, nv_sat);
            wr_en     = 1'b1;
            wr_data   = '{nice: nv_sat, rcpu: rdq_r.rcpu, prio: new_prio};
            yield_nxt = (rdq_r.prio > new_prio);
          end
          ACT_SLICE: begin
            slc_nxt = 8'd0;
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        calc_v   = trunc_p(mul_p_r)
                 + PW'(C1) * PW'({1'b0, rdy_r} + 8'(!idle_r));
        load_nxt = sat32(calc_v);
        state_nxt = S_DVI;
      end
      S_DVI: begin
        rem_nxt   = DW'(twice);
        den_nxt   = (DW-1)'(twice) + (DW-1)'(FONE);
        coeff_nxt = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // Restoring divide: one quotient bit per cycle
        if (div_sh >= DW'(den_r)) begin
          rem_nxt   = div_sh - DW'(den_r);
          coeff_nxt = {coeff_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt   = div_sh;
          coeff_nxt = {coeff_r[FRAC_BITS-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(FRAC_BITS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        if (sweep_r == M_END) begin
          sweep_nxt = '0;
          state_nxt = pflag_r ? S_PRD : S_ORD;
        end else if (live_r[swp_w]) begin
          rd_en     = 1'b1;
          rd_addr   = swp_w;
          state_nxt = S_DWT;
        end else begin
          sweep_nxt = sweep_r + SW'(1);
        end
      end
      S_DWT: begin
        mul_a     = rdq_r.rcpu;
        mul_b     = $signed({2'b00, coeff_r});
        state_nxt = S_DWR;
      end
      S_DWR: begin
        calc_v    = trunc_p(mul_p_r) + (PW'(rdq_r.nice) <<< FRAC_BITS);
        wr_en     = 1'b1;
        wr_addr   = swp_w;
        wr_data   = '{nice: rdq_r.nice, rcpu: sat32(calc_v), prio: rdq_r.prio};
        sweep_nxt = sweep_r + SW'(1);
        state_nxt = S_DRD;
      end
      S_PRD: begin
        if (sweep_r == M_END) begin
          state_nxt = S_ORD;
        end else if (live_r[swp_w]) begin
          rd_en     = 1'b1;
          rd_addr   = swp_w;
          state_nxt = S_PWR;
        end else begin
          sweep_nxt = sweep_r + SW'(1);
        end
      end
      S_PWR: begin
        wr_en     = 1'b1;
        wr_addr   = swp_w;
        wr_data   = '{nice: rdq_r.nice, rcpu: rdq_r.rcpu,
                      prio: calc_prio(rdq_r.rcpu, rdq_r.nice)};
        sweep_nxt = sweep_r + SW'(1);
        state_nxt = S_PRD;
      end
      S_ORD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_w;
        state_nxt = S_OMA;
      end
      S_OMA: begin
        mul_a     = rdq_r.rcpu;
        mul_b     = MB_W'(SCALE);
        state_nxt = S_OMB;
      end
      S_OMB: begin
        calc_v = round_p(mul_p_r);
        if (calc_v > PW'(RX_LIM))       rx_nxt = 22'(RX_LIM);
        else if (calc_v < -PW'(RX_LIM)) rx_nxt = -22'(RX_LIM);
        else                            rx_nxt = calc_v[21:0];
        mul_a     = load_r;
        mul_b     = MB_W'(SCALE);
        state_nxt = S_OFN;
      end
      S_OFN: begin
        calc_v = round_p(mul_p_r);
        if (calc_v > PW'(LX_LIM)) olx_nxt = 13'(LX_LIM);
        else if (calc_v < 0)      olx_nxt = '0;
        else                      olx_nxt = calc_v[12:0];
        oprio_nxt     = rdq_r.prio;
        orx_nxt       = rx_r;
        oyld_nxt      = yield_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      load_r      <= '0;
      sec_r       <= '0;
      qtr_r       <= '0;
      slc_r       <= '0;
      en_r        <= 1'b1;
      tsl_r       <= 8'd4;
      tps_r       <= 10'd100;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      load_r      <= load_nxt;
      sec_r       <= sec_nxt;
      qtr_r       <= qtr_nxt;
      slc_r       <= slc_nxt;
      en_r        <= en_nxt;
      tsl_r       <= tsl_nxt;
      tps_r       <= tps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    idx_r   <= idx_nxt;
    par_r   <= par_nxt;
    nv_r    <= nv_nxt;
    rdy_r   <= rdy_nxt;
    idle_r  <= idle_nxt;
    yield_r <= yield_nxt;
    pflag_r <= pflag_nxt;
    sweep_r <= sweep_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    coeff_r <= coeff_nxt;
    dcnt_r  <= dcnt_nxt;
    rx_r    <= rx_nxt;
    oprio_r <= oprio_nxt;
    orx_r   <= orx_nxt;
    olx_r   <= olx_nxt;
    oyld_r  <= oyld_nxt;
    mul_p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (wr_en) thread_mem[wr_addr] <= wr_data;
    if (rd_en) rdq_r <= thread_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_priority_res    = oprio_r;
  assign out_cpu_usage_x100  = orx_r;
  assign out_load_avg_x100   = olx_r;
  assign out_yield_request   = oyld_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_load_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !load_r[RC_W-1]) else $error("load average went negative");
`endif

endmodule

// ----- dv/bsd_mlfq_priority_engine_tb.sv -----
// Testbench for the MLFQ priority engine: random and directed requests checked against a predictor.
module bsd_mlfq_priority_engine_tb;
  import bmlfq_pkg::*;

  // Spare action codes behave as a read.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam longint ONE_FX = 64'sd16384;  // 1.0 in 17.14

  typedef struct {
    logic [2:0]        act;
    logic [5:0]        tid;
    logic [5:0]        pid;
    logic signed [5:0] nice;
    logic [6:0]        ready;
    logic              idle;
  } sched_req_t;

  typedef struct {
    logic [5:0]         prio;
    logic signed [21:0] rcpu;
    logic [12:0]        load;
    logic               yld;
  } sched_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_action = '0;
  logic [5:0] in_thread_index = '0;
  logic [5:0] in_parent_index = '0;
  logic signed [5:0] in_nice_value = '0;
  logic [6:0] in_ready_count = '0;
  logic in_running_is_idle = 1'b0;
  logic out_valid;
  logic [5:0] out_priority_res;
  logic signed [21:0] out_cpu_usage_x100;
  logic [12:0] out_load_avg_x100;
  logic out_yield_request;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bsd_mlfq_priority_engine uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: thread table, load average, counters, registers.
  bit                 pr_live [64];
  logic signed [31:0] pr_nice [64];
  logic signed [31:0] pr_rcpu [64];
  logic [5:0]         pr_prio [64];
  logic signed [31:0] pr_load;
  int unsigned        pr_sec_cnt, pr_qtr_cnt, pr_slice_cnt;
  bit                 pr_enable = 1'b1;
  int unsigned        pr_slice_len = 4;
  int unsigned        pr_tps = 100;

  sched_req_t  pending_reqs[$];
  sched_resp_t expected_resps[$];
  int          err_count = 0;
  bit          idle_en = 1'b1;   // random idling on the request side
  bit          hold_reqs = 1'b0; // park the driver until all expected responses are in
  int          gap_left = 0;

  // Stimulus-side view of the table: which slots hold defined values.
  bit gen_written [64];
  bit gen_alive [64];

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint fx_round(longint v);
    if (v >= 0) return (v + ONE_FX / 2) / ONE_FX;
    return -((-v + ONE_FX / 2) / ONE_FX);
  endfunction

  function automatic logic [5:0] prio_of(int i);
    longint p;
    p = PRIO_TOP - fx_round(longint'(pr_rcpu[i]) / 4) - 2 * longint'(pr_nice[i]);
    if (p > PRIO_TOP) p = PRIO_TOP;
    if (p < 0) p = 0;
    return p[5:0];
  endfunction

  // Once-per-second load update and cpu usage decay.
  function automatic void decay_second(int unsigned ready);
    longint c59, c1, l, twice, coeff;
    c59 = (59 * ONE_FX) / 60;
    c1 = ONE_FX / 60;
    l = (longint'(pr_load) * c59) / ONE_FX + c1 * longint'(ready);
    pr_load = sat32(l);
    twice = 2 * longint'(pr_load);
    if (twice < 0) twice = 0;
    coeff = (twice * ONE_FX) / (twice + ONE_FX);
    for (int i = 0; i < 64; i++)
      if (pr_live[i])
        pr_rcpu[i] = sat32((coeff * longint'(pr_rcpu[i])) / ONE_FX
                           + longint'(pr_nice[i]) * ONE_FX);
  endfunction

  // Advance the predictor by one accepted request and return the expected response.
  function automatic sched_resp_t sched_step(sched_req_t r);
    sched_resp_t s;
    int idx, par, nv;
    int unsigned tps, prev;
    bit yld, sec;
    longint rx, lx;
    idx = r.tid;
    par = r.pid;
    nv = r.nice;
    yld = 1'b0;
    case (r.act)
      ACT_TICK: begin
        tps = (pr_tps == 0) ? 1 : pr_tps;
        if (pr_enable && !r.idle && pr_live[idx])
          pr_rcpu[idx] = sat32(longint'(pr_rcpu[idx]) + ONE_FX);
        pr_sec_cnt++;
        sec = pr_sec_cnt >= tps;
        if (sec) pr_sec_cnt = 0;
        pr_qtr_cnt = (pr_qtr_cnt + 1) & 3;
        if (pr_enable) begin
          if (sec) decay_second(r.ready + (r.idle ? 0 : 1));
          if (pr_qtr_cnt == 0)
            for (int i = 0; i < 64; i++)
              if (pr_live[i]) pr_prio[i] = prio_of(i);
        end
        if (pr_slice_cnt < 255) pr_slice_cnt++;
        if (pr_slice_cnt >= pr_slice_len) yld = 1'b1;
      end
      ACT_CREATE: begin
        if (par == idx) begin
          pr_nice[idx] = 0;
          pr_rcpu[idx] = 0;
        end else begin
          pr_nice[idx] = pr_nice[par];
          pr_rcpu[idx] = pr_rcpu[par];
        end
        pr_prio[idx] = prio_of(idx);
        pr_live[idx] = 1'b1;
      end
      ACT_EXIT: pr_live[idx] = 1'b0;
      ACT_NICE: begin
        prev = pr_prio[idx];
        if (nv > NICE_LIM) nv = NICE_LIM;
        if (nv < -NICE_LIM) nv = -NICE_LIM;
        pr_nice[idx] = nv;
        pr_prio[idx] = prio_of(idx);
        if (prev > pr_prio[idx]) yld = 1'b1;
      end
      ACT_SLICE: pr_slice_cnt = 0;
      default: ;
    endcase
    rx = fx_round(longint'(pr_rcpu[idx]) * SCALE);
    if (rx > RX_LIM) rx = RX_LIM;
    if (rx < -RX_LIM) rx = -RX_LIM;
    lx = fx_round(longint'(pr_load) * SCALE);
    if (lx > LX_LIM) lx = LX_LIM;
    if (lx < 0) lx = 0;
    s.prio = pr_prio[idx];
    s.rcpu = rx[21:0];
    s.load = lx[12:0];
    s.yld = yld;
    return s;
  endfunction

  // Driver: present the head of the pending queue, hold it while busy,
  // insert random idle bursts between requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_resps.push_back(sched_step(pending_reqs[0]));
        void'(pending_reqs.pop_front());
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_reqs) begin
          start <= 1'b1;
          in_action <= pending_reqs[0].act;
          in_thread_index <= pending_reqs[0].tid;
          in_parent_index <= pending_reqs[0].pid;
          in_nice_value <= pending_reqs[0].nice;
          in_ready_count <= pending_reqs[0].ready;
          in_running_is_idle <= pending_reqs[0].idle;
          if (idle_en && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed response must match the oldest expectation.
  always @(posedge clk) begin
    sched_resp_t e;
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected response prio=%0d rcpu=%0d load=%0d yield=%0b", $time,
                 out_priority_res, out_cpu_usage_x100, out_load_avg_x100, out_yield_request);
        err_count++;
      end else begin
        e = expected_resps.pop_front();
        if (out_priority_res !== e.prio) begin
          $display("%0t: priority expected %0d got %0d", $time, e.prio, out_priority_res);
          err_count++;
        end
        if (out_cpu_usage_x100 !== e.rcpu) begin
          $display("%0t: cpu_usage_x100 expected %0d got %0d", $time, e.rcpu,
                   out_cpu_usage_x100);
          err_count++;
        end
        if (out_load_avg_x100 !== e.load) begin
          $display("%0t: load_avg_x100 expected %0d got %0d", $time, e.load,
                   out_load_avg_x100);
          err_count++;
        end
        if (out_yield_request !== e.yld) begin
          $display("%0t: yield expected %0b got %0b", $time, e.yld, out_yield_request);
          err_count++;
        end
      end
    end
  end

  function automatic int pick_written();
    int cands[$];
    for (int i = 0; i < 64; i++)
      if (gen_written[i] && (gen_alive[i] || $urandom_range(0, 3) == 0)) cands.push_back(i);
    if (cands.size() == 0)
      for (int i = 0; i < 64; i++) if (gen_written[i]) cands.push_back(i);
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Queue one request and track which slots become defined.
  function automatic void queue_req(logic [2:0] act, int tid, int pid, int nice, int ready,
                                    bit idle);
    sched_req_t r;
    r.act = act;
    r.tid = tid[5:0];
    r.pid = pid[5:0];
    r.nice = nice[5:0];
    r.ready = ready[6:0];
    r.idle = idle;
    if (act == ACT_CREATE) begin
      gen_written[tid] = 1'b1;
      gen_alive[tid] = 1'b1;
    end
    if (act == ACT_EXIT) gen_alive[tid] = 1'b0;
    pending_reqs.push_back(r);
  endfunction

  // Random request; only slots with defined contents are ever read as a source,
  // except by a create whose parent is itself.
  function automatic void queue_random();
    int w, tid, pid, nice;
    logic [2:0] act;
    bit any;
    any = 1'b0;
    for (int i = 0; i < 64; i++) any |= gen_written[i];
    w = $urandom_range(0, 99);
    if (!any) act = ACT_CREATE;
    else if (w < 50) act = ACT_TICK;
    else if (w < 62) act = ACT_CREATE;
    else if (w < 68) act = ACT_EXIT;
    else if (w < 80) act = ACT_NICE;
    else if (w < 88) act = ACT_SLICE;
    else if (w < 96) act = ACT_READ;
    else act = (w < 98) ? ACT_SPARE6 : ACT_SPARE7;
    nice = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 40) - 20;
    if (act == ACT_CREATE) begin
      tid = $urandom_range(0, 63);
      pid = (!any || $urandom_range(0, 2) == 0) ? tid : pick_written();
    end else begin
      tid = pick_written();
      pid = $urandom_range(0, 63);
    end
    queue_req(act, tid, pid, nice, $urandom_range(0, 127), $urandom_range(0, 4) == 0);
  endfunction

  // Let every queued request go through and every response come back.
  task automatic drain();
    do @(negedge clk); while (pending_reqs.size() > 0 || expected_resps.size() > 0 || busy);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE: pr_enable = val[0];
      REG_SLICE:  pr_slice_len = val[7:0];
      default:    pr_tps = val[9:0];
    endcase
  endtask

  task automatic set_regs(bit en, int slice_len, int tps);
    reg_write(REG_ENABLE, en);
    reg_write(REG_SLICE, slice_len);
    reg_write(REG_TPS, tps);
  endtask

  initial begin
    // Register settings per phase: enable, slice length, ticks per second.
    int ph_en[7] = '{1, 1, 0, 1, 1, 1, 1};
    int ph_sl[7] = '{1, 255, 3, 2, 7, 4, 5};
    int ph_tp[7] = '{1, 1023, 5, 0, 3, 2, 1};
    pr_load = 0;
    pr_sec_cnt = 0;
    pr_qtr_cnt = 0;
    pr_slice_cnt = 0;
    for (int i = 0; i < 64; i++) begin
      pr_live[i] = 1'b0;
      pr_nice[i] = 0;
      pr_rcpu[i] = 0;
      pr_prio[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under reset register values.
    queue_req(ACT_CREATE, 0, 0, 0, 0, 0);        // initial thread
    queue_req(ACT_CREATE, 1, 0, 0, 0, 0);        // inherit from parent
    queue_req(ACT_NICE, 1, 0, 20, 0, 0);         // weakest nice, priority drops
    queue_req(ACT_NICE, 1, 0, -20, 0, 0);
    queue_req(ACT_NICE, 0, 0, 31, 127, 0);       // saturate nice high
    queue_req(ACT_NICE, 0, 0, -32, 0, 0);        // saturate nice low
    queue_req(ACT_TICK, 0, 63, -1, 127, 0);
    queue_req(ACT_TICK, 0, 0, 0, 0, 1);          // idle thread runs
    queue_req(ACT_EXIT, 1, 0, 0, 0, 0);
    queue_req(ACT_TICK, 1, 0, 0, 64, 0);         // charge of a dead slot is dropped
    queue_req(ACT_NICE, 1, 0, 5, 0, 0);          // nice on a dead slot
    queue_req(ACT_READ, 1, 0, 0, 0, 0);
    queue_req(ACT_CREATE, 1, 0, 0, 0, 0);
    queue_req(ACT_TICK, 1, 0, 0, 3, 0);
    queue_req(ACT_SLICE, 0, 0, 0, 0, 0);
    queue_req(ACT_TICK, 0, 0, 0, 0, 0);
    queue_req(ACT_CREATE, 63, 63, 0, 0, 0);
    queue_req(ACT_EXIT, 63, 0, 0, 0, 0);
    queue_req(ACT_READ, 63, 63, 0, 127, 1);      // stale values after exit
    queue_req(ACT_SPARE6, 0, 0, 0, 0, 0);
    queue_req(ACT_SPARE7, 63, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      set_regs(ph_en[ph], ph_sl[ph], ph_tp[ph]);
      idle_en = (ph < 6);
      for (int k = 0; k < 135; k++) queue_random();
      if (ph == 2) begin
        // Pause the requests midway until the block has answered everything so far.
        while (pending_reqs.size() > 70) @(negedge clk);
        hold_reqs = 1'b1;
        do @(negedge clk); while (expected_resps.size() > 0 || busy);
        hold_reqs = 1'b0;
        for (int k = 0; k < 10; k++) queue_random();
      end
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
src/bmlfq_pkg.sv
src/bsd_mlfq_priority_engine.sv
dv/bsd_mlfq_priority_engine_tb.sv
